FILE: rtl/spc_pkg.sv
// Shared types and constants for the simple path counter.
// Used by every file in rtl/; depends on nothing else.
package spc_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int KIND_W           = 2;
  localparam int VERTEX_W         = 4;
  localparam int CFG_W            = 5;
  localparam int COUNT_W          = 64;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 5'd16;

  // item kinds; the fourth code is unused and dropped
  localparam logic [KIND_W-1:0] KIND_ADD_EDGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] path_count;
    logic               overflowed;
  } result_t;

  // one search step's decision
  typedef struct packed {
    logic pop;        // candidates exhausted, backtrack
    logic advance;    // move the top frame to its next candidate
    logic take_path;  // candidate is the target: one more path
    logic push;       // candidate is a fresh vertex: descend
  } step_t;

endpackage

FILE: rtl/spc_step.sv
// Shared search step unit: checks one candidate of the top stack frame.
// Depends on spc_pkg.
module spc_step #(
  parameter int MAX_VERTICES = spc_pkg::MAX_VERTICES_DEF,
  parameter int VW = $clog2(MAX_VERTICES),
  parameter int NW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                    active,
  input  logic [MAX_VERTICES-1:0] row,
  input  logic [MAX_VERTICES-1:0] visited,
  input  logic [NW-1:0]           cand,
  input  logic [NW-1:0]           n_eff,
  input  logic [VW-1:0]           target,
  input  logic [NW-1:0]           depth,
  output spc_pkg::step_t          step
);

  logic [VW-1:0] cand_idx;
  logic          fresh;

  assign cand_idx = cand[VW-1:0];
  assign fresh    = row[cand_idx] && !visited[cand_idx];

  always_comb begin
    step = '0;
    if (active) begin
      if (cand >= n_eff) begin
        step.pop = 1'b1;
      end else begin
        step.advance   = 1'b1;
        step.take_path = fresh && (cand_idx == target);
        step.push      = fresh && (cand_idx != target) &&
                         (depth < NW'(MAX_VERTICES));
      end
    end
  end

endmodule

FILE: rtl/spc_sat_counter.sv
// 64-bit saturating path counter with sticky overflow flag.
// Depends on spc_pkg.
module spc_sat_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic                          set_one,
  input  logic                          inc,
  output logic [spc_pkg::COUNT_W-1:0]   total,
  output logic                          sat
);

  localparam logic [spc_pkg::COUNT_W-1:0] ALL_ONES = '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      sat   <= 1'b0;
    end else if (clr) begin
      total <= set_one ? spc_pkg::COUNT_W'(1) : '0;
      sat   <= 1'b0;
    end else if (inc) begin
      if (total != ALL_ONES) begin
        total <= total + spc_pkg::COUNT_W'(1);
      end
      // saturated once the count reaches all ones
      if (total >= ALL_ONES - spc_pkg::COUNT_W'(1)) begin
        sat <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/simple_path_counter.sv
// Simple path counter: counts simple directed paths from vertex 0 to the last vertex in use.
// Edge add / clear words: accepted one per cycle while idle, no result.
// Count word: result valid after the search, which the single shared step unit carries out by
// walking the explicit DFS stack, one step per candidate tried and per backtrack; a one-vertex
// graph skips the search. Busy until the result is loaded.
// rst (synchronous, active high) clears the adjacency matrix, sequencer and result valid;
// vertex_count resets to 16.
module simple_path_counter #(
  parameter int MAX_VERTICES = spc_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration: vertex_count
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [spc_pkg::CFG_W-1:0] cfg_data,
  // input words
  input  logic                      item_valid,
  output logic                      item_stall,
  input  spc_pkg::item_t            item,
  // result words
  output logic                      result_valid,
  input  logic                      result_stall,
  output spc_pkg::result_t          result
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  spc_pkg::state_t state, state_next;

  logic [spc_pkg::CFG_W-1:0] vertex_count;
  logic [MAX_VERTICES-1:0]   adj [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   visited;
  logic [NW-1:0]             depth;
  // explicit recursion stack; entries written before they are read
  logic [VW-1:0]             stk_vertex [MAX_VERTICES];
  logic [NW-1:0]             stk_next   [MAX_VERTICES];

  logic                      accept;
  logic                      start;
  logic                      load_result;
  logic                      searching;
  logic [NW-1:0]             n_eff;
  logic [VW-1:0]             target;
  logic [VW-1:0]             top_idx;
  logic [VW-1:0]             top_v;
  logic [NW-1:0]             top_next;
  logic [VW-1:0]             push_idx;
  logic                      edge_ok;
  spc_pkg::step_t            step;
  logic [spc_pkg::COUNT_W-1:0] total;
  logic                      sat;

  assign cfg_ready = !rst;
  assign accept    = item_valid && !item_stall;

  // clamp vertex_count into 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = NW'(1);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vertex_count);
    end
  end
  assign target = VW'(n_eff - NW'(1));

  assign top_idx  = VW'(depth - NW'(1));
  assign top_v    = stk_vertex[top_idx];
  assign top_next = stk_next[top_idx];
  assign push_idx = VW'(depth);

  assign searching = (state == spc_pkg::ST_SEARCH) && (depth != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= spc_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // adjacency matrix; edges naming vertices beyond the matrix are dropped
  assign edge_ok = (int'(item.from_vertex) < MAX_VERTICES) &&
                   (int'(item.to_vertex) < MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else if (accept && item.kind == spc_pkg::KIND_CLEAR) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else if (accept && item.kind == spc_pkg::KIND_ADD_EDGE && edge_ok) begin
      adj[VW'(item.from_vertex)][VW'(item.to_vertex)] <= 1'b1;
    end
  end

  spc_step #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .NW           (NW)
  ) u_step (
    .active  (searching),
    .row     (adj[top_v]),
    .visited (visited),
    .cand    (top_next),
    .n_eff   (n_eff),
    .target  (target),
    .depth   (depth),
    .step    (step)
  );

  // path membership and stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      depth   <= '0;
    end else if (start) begin
      visited <= MAX_VERTICES'(1);   // vertex 0 is on every path
      depth   <= NW'(1);
    end else if (step.pop) begin
      visited[top_v] <= 1'b0;
      depth          <= depth - NW'(1);
    end else if (step.push) begin
      visited[top_next[VW-1:0]] <= 1'b1;
      depth                     <= depth + NW'(1);
    end
  end

  // stack contents, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      stk_vertex[0] <= '0;
      stk_next[0]   <= '0;
    end else if (step.advance) begin
      stk_next[top_idx] <= top_next + NW'(1);
      if (step.push) begin
        stk_vertex[push_idx] <= top_next[VW-1:0];
        stk_next[push_idx]   <= '0;
      end
    end
  end

  spc_sat_counter u_count (
    .clk     (clk),
    .rst     (rst),
    .clr     (start),
    .set_one (start && n_eff == NW'(1)),
    .inc     (step.take_path),
    .total   (total),
    .sat     (sat)
  );

  // sequencer: next state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spc_pkg::ST_IDLE: begin
        if (accept && item.kind == spc_pkg::KIND_COUNT) begin
          state_next = (n_eff == NW'(1)) ? spc_pkg::ST_FINISH : spc_pkg::ST_SEARCH;
        end
      end
      spc_pkg::ST_SEARCH: begin
        if (depth == '0) begin
          state_next = spc_pkg::ST_FINISH;
        end
      end
      spc_pkg::ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          state_next = spc_pkg::ST_IDLE;
        end
      end
      default: state_next = spc_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    item_stall  = rst || (state != spc_pkg::ST_IDLE);
    start       = accept && (item.kind == spc_pkg::KIND_COUNT);
    load_result = (state == spc_pkg::ST_FINISH) && (!result_valid || !result_stall);
  end

  // output register: holds a finished count while downstream stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.path_count <= total;
      result.overflowed <= sat;
    end
  end

endmodule

FILE: rtl/spc_checker.sv
// Port-level checks for simple_path_counter, bound to the top level.
// Depends on spc_pkg and simple_path_counter.
module spc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_stall,
  input spc_pkg::item_t            item,
  input logic                      result_valid,
  input logic                      result_stall,
  input spc_pkg::result_t          result
);

  // no result word straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // a count keeps the block busy on the next cycle
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.kind == spc_pkg::KIND_COUNT) |=> item_stall)
    else $error("input taken right after a count");

  // the overflow flag only accompanies a saturated count
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.overflowed) |-> (&result.path_count))
    else $error("overflow flagged on a count below maximum");

  // stalled result word stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule

bind simple_path_counter spc_checker u_spc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
